/* src/byte_transliterator_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the byte transliterator unit
// Short forms for clocked implication checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef BYTE_TRANSLITERATOR_UNIT_MACROS_SVH
`define BYTE_TRANSLITERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BXL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BXL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays active through reset.
`define BXL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bxl_pkg.sv */
// ----------------------------------------------------------------------------
// Byte transliterator package
// Shared widths, operation and status codes, result and memory request types.
// ----------------------------------------------------------------------------
`default_nettype none

package bxl_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned BYTE_VALUES    = 256;
    localparam int unsigned OP_W           = 3;
    localparam int unsigned ST_W           = 3;
    localparam int unsigned MEM_W          = 8;
    localparam int unsigned SOURCE_MAX_DEF = 256;
    localparam int unsigned TARGET_MAX_DEF = 256;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR,
        OP_ADD_SRC,
        OP_SRC_MARK,
        OP_ADD_TGT,
        OP_TGT_MARK,
        OP_FINISH,
        OP_TRANSLATE
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_NO_START,
        ST_REVERSED,
        ST_DANGLING,
        ST_OVERFLOW
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_status           status;
    } t_result;

    // One write port and one read address for a synchronous memory.
    typedef struct packed {
        logic             we;
        logic [MEM_W-1:0] waddr;
        logic [MEM_W-1:0] wdata;
        logic [MEM_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* src/bxl_ifs.sv */
// ----------------------------------------------------------------------------
// Byte transliterator channel interfaces
// Request channel carries operation items, response channel carries results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bxl_req_if import bxl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface bxl_rsp_if import bxl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [ST_W-1:0]   status;

    modport source (output valid, output out_byte, output status, input ready);
    modport sink (input valid, input out_byte, input status, output ready);
endinterface

`default_nettype wire

/* src/bxl_ram.sv */
// ----------------------------------------------------------------------------
// Byte transliterator memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bxl_ram import bxl_pkg::*; #(
    parameter int unsigned DATA_W = BYTE_W,
    parameter int unsigned DEPTH  = BYTE_VALUES,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[ADDR_W-1:0]] <= i_req.wdata[DATA_W-1:0];
        end
        r_rdata <= r_mem[i_req.raddr[ADDR_W-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/bxl_ctrl.sv */
// ----------------------------------------------------------------------------
// Byte transliterator sequencer
// Decodes items, keeps list counters and presence flags, drives the memories.
// ----------------------------------------------------------------------------
`default_nettype none

module bxl_ctrl import bxl_pkg::*; #(
    parameter int unsigned SOURCE_MAX = SOURCE_MAX_DEF,
    parameter int unsigned TARGET_MAX = TARGET_MAX_DEF,
    localparam int unsigned SAW = (SOURCE_MAX > 1) ? $clog2(SOURCE_MAX) : 1,
    localparam int unsigned TAW = (TARGET_MAX > 1) ? $clog2(TARGET_MAX) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_res_free,
    output logic              o_res_we,
    output t_result           o_res,
    output t_mem_req          o_pos,
    input  logic [SAW-1:0]    i_pos_rdata,
    output t_mem_req          o_src,
    input  logic [BYTE_W-1:0] i_src_rdata,
    output t_mem_req          o_tgt,
    input  logic [BYTE_W-1:0] i_tgt_rdata
);

    localparam int unsigned SCW   = $clog2(SOURCE_MAX + 1);
    localparam int unsigned TCW   = $clog2(TARGET_MAX + 1);
    localparam int unsigned CMP_W = BYTE_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TR_POS,
        S_TR_TGT,
        S_POP,
        S_RANGE
    } t_state;

    t_state                 r_state, n_state;
    logic [SCW-1:0]         r_src_cnt, n_src_cnt;
    logic [TCW-1:0]         r_tgt_cnt, n_tgt_cnt;
    logic [BYTE_W-1:0]      r_last_src, n_last_src;
    logic [BYTE_W-1:0]      r_last_tgt, n_last_tgt;
    logic                   r_src_pend, n_src_pend;
    logic                   r_tgt_pend, n_tgt_pend;
    logic [BYTE_VALUES-1:0] r_present, n_present;
    logic [BYTE_W-1:0]      r_cur, n_cur;
    logic [BYTE_W-1:0]      r_end, n_end;
    logic                   r_is_src, n_is_src;

    t_op               op;
    logic              accept;
    logic              lst_src;
    logic              src_full, tgt_full;
    logic              sel_full, sel_empty, sel_pend;
    logic [BYTE_W-1:0] sel_last;
    logic [SCW-1:0]    src_cnt_m1, src_cnt_m2;
    logic [TCW-1:0]    tgt_cnt_m1, tgt_cnt_m2;
    logic [CMP_W-1:0]  pos_x, tcnt_x;
    logic [TAW-1:0]    tgt_rd_addr;
    logic              push_en, push_src;
    logic [BYTE_W-1:0] push_byte;

    assign op      = t_op'(i_op);
    assign o_ready = (r_state == S_IDLE) && i_res_free;
    assign accept  = i_valid && o_ready;

    // In idle the item's own operation picks the list, later the latched choice.
    assign lst_src   = (r_state == S_IDLE) ? (op == OP_ADD_SRC) : r_is_src;
    assign src_full  = (r_src_cnt == SCW'(SOURCE_MAX));
    assign tgt_full  = (r_tgt_cnt == TCW'(TARGET_MAX));
    assign sel_full  = lst_src ? src_full : tgt_full;
    assign sel_empty = lst_src ? (r_src_cnt == '0) : (r_tgt_cnt == '0);
    assign sel_pend  = lst_src ? r_src_pend : r_tgt_pend;
    assign sel_last  = lst_src ? r_last_src : r_last_tgt;

    assign src_cnt_m1 = r_src_cnt - SCW'(1);
    assign src_cnt_m2 = src_cnt_m1 - SCW'(1);
    assign tgt_cnt_m1 = r_tgt_cnt - TCW'(1);
    assign tgt_cnt_m2 = tgt_cnt_m1 - TCW'(1);

    // A first position past the end of the target list selects its last byte.
    assign pos_x       = CMP_W'(i_pos_rdata);
    assign tcnt_x      = CMP_W'(r_tgt_cnt);
    assign tgt_rd_addr = (pos_x >= tcnt_x) ? tgt_cnt_m1[TAW-1:0] : pos_x[TAW-1:0];

    always_comb begin
        n_state    = r_state;
        n_src_cnt  = r_src_cnt;
        n_tgt_cnt  = r_tgt_cnt;
        n_last_src = r_last_src;
        n_last_tgt = r_last_tgt;
        n_src_pend = r_src_pend;
        n_tgt_pend = r_tgt_pend;
        n_present  = r_present;
        n_cur      = r_cur;
        n_end      = r_end;
        n_is_src   = r_is_src;
        o_pos      = '0;
        o_src      = '0;
        o_tgt      = '0;
        o_res_we   = 1'b0;
        o_res      = '{out_byte: '0, status: ST_OK};
        push_en    = 1'b0;
        push_src   = 1'b0;
        push_byte  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_CLEAR: begin
                            n_src_cnt  = '0;
                            n_tgt_cnt  = '0;
                            n_last_src = '0;
                            n_last_tgt = '0;
                            n_src_pend = 1'b0;
                            n_tgt_pend = 1'b0;
                            n_present  = '0;
                            o_res_we   = 1'b1;
                        end
                        OP_ADD_SRC, OP_ADD_TGT: begin
                            if (!sel_pend) begin
                                o_res_we = 1'b1;
                                if (sel_full) begin
                                    o_res.status = ST_OVERFLOW;
                                end else begin
                                    push_en   = 1'b1;
                                    push_src  = lst_src;
                                    push_byte = i_byte;
                                end
                            end else begin
                                if (lst_src) begin
                                    n_src_pend = 1'b0;
                                end else begin
                                    n_tgt_pend = 1'b0;
                                end
                                if (sel_empty) begin
                                    o_res_we     = 1'b1;
                                    o_res.status = ST_NO_START;
                                end else if (sel_last > i_byte) begin
                                    // Reversed: fetch the start's first position and
                                    // the byte that becomes last once it is removed.
                                    o_pos.raddr = sel_last;
                                    o_src.raddr = MEM_W'(src_cnt_m2[SAW-1:0]);
                                    o_tgt.raddr = MEM_W'(tgt_cnt_m2[TAW-1:0]);
                                    n_cur       = sel_last;
                                    n_is_src    = lst_src;
                                    n_state     = S_POP;
                                end else if (sel_last == i_byte) begin
                                    o_res_we = 1'b1;
                                end else begin
                                    // Removing the start and appending it again leaves
                                    // the list as it was, so the run begins one above.
                                    n_cur    = sel_last + BYTE_W'(1);
                                    n_end    = i_byte;
                                    n_is_src = lst_src;
                                    n_state  = S_RANGE;
                                end
                            end
                        end
                        OP_SRC_MARK: begin
                            n_src_pend = 1'b1;
                            o_res_we   = 1'b1;
                        end
                        OP_TGT_MARK: begin
                            n_tgt_pend = 1'b1;
                            o_res_we   = 1'b1;
                        end
                        OP_FINISH: begin
                            o_res_we = 1'b1;
                            if (r_src_pend || r_tgt_pend) begin
                                o_res.status = ST_DANGLING;
                            end
                        end
                        OP_TRANSLATE: begin
                            if ((i_byte == '0) || (r_tgt_cnt == '0) || !r_present[i_byte]) begin
                                o_res_we       = 1'b1;
                                o_res.out_byte = i_byte;
                            end else begin
                                o_pos.raddr = i_byte;
                                n_state     = S_TR_POS;
                            end
                        end
                        default: begin
                            o_res_we = 1'b1;
                        end
                    endcase
                end
            end
            S_TR_POS: begin
                o_tgt.raddr = MEM_W'(tgt_rd_addr);
                n_state     = S_TR_TGT;
            end
            S_TR_TGT: begin
                o_res_we       = 1'b1;
                o_res.out_byte = i_tgt_rdata;
                n_state        = S_IDLE;
            end
            S_POP: begin
                if (r_is_src) begin
                    if (i_pos_rdata == src_cnt_m1[SAW-1:0]) begin
                        n_present[r_cur] = 1'b0;
                    end
                    n_src_cnt  = src_cnt_m1;
                    n_last_src = (src_cnt_m1 != '0) ? i_src_rdata : '0;
                end else begin
                    n_tgt_cnt  = tgt_cnt_m1;
                    n_last_tgt = (tgt_cnt_m1 != '0) ? i_tgt_rdata : '0;
                end
                o_res_we     = 1'b1;
                o_res.status = ST_REVERSED;
                n_state      = S_IDLE;
            end
            S_RANGE: begin
                if (sel_full) begin
                    o_res_we     = 1'b1;
                    o_res.status = ST_OVERFLOW;
                    n_state      = S_IDLE;
                end else begin
                    push_en   = 1'b1;
                    push_src  = r_is_src;
                    push_byte = r_cur;
                    if (r_cur == r_end) begin
                        o_res_we = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_cur = r_cur + BYTE_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Append one byte to the selected list; fullness is checked by the caller.
        if (push_en) begin
            if (push_src) begin
                o_src.we    = 1'b1;
                o_src.waddr = MEM_W'(r_src_cnt[SAW-1:0]);
                o_src.wdata = push_byte;
                if (!r_present[push_byte]) begin
                    n_present[push_byte] = 1'b1;
                    o_pos.we             = 1'b1;
                    o_pos.waddr          = push_byte;
                    o_pos.wdata          = MEM_W'(r_src_cnt[SAW-1:0]);
                end
                n_src_cnt  = r_src_cnt + SCW'(1);
                n_last_src = push_byte;
            end else begin
                o_tgt.we    = 1'b1;
                o_tgt.waddr = MEM_W'(r_tgt_cnt[TAW-1:0]);
                o_tgt.wdata = push_byte;
                n_tgt_cnt   = r_tgt_cnt + TCW'(1);
                n_last_tgt  = push_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_src_cnt  <= '0;
            r_tgt_cnt  <= '0;
            r_last_src <= '0;
            r_last_tgt <= '0;
            r_src_pend <= 1'b0;
            r_tgt_pend <= 1'b0;
            r_present  <= '0;
            r_is_src   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_src_cnt  <= n_src_cnt;
            r_tgt_cnt  <= n_tgt_cnt;
            r_last_src <= n_last_src;
            r_last_tgt <= n_last_tgt;
            r_src_pend <= n_src_pend;
            r_tgt_pend <= n_tgt_pend;
            r_present  <= n_present;
            r_is_src   <= n_is_src;
        end
        r_cur <= n_cur;
        r_end <= n_end;
    end

endmodule

`default_nettype wire

/* src/bxl_outq.sv */
// ----------------------------------------------------------------------------
// Byte transliterator result queue
// Output register plus one holding slot, so a single stalled result does not hold the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bxl_outq import bxl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_we,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result r_hold, n_hold;
    logic    r_hold_valid, n_hold_valid;
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    logic    out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_free   = !r_hold_valid || out_free;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_comb begin
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_ready;
        if (r_hold_valid && out_free) begin
            n_out        = r_hold;
            n_out_valid  = 1'b1;
            n_hold_valid = 1'b0;
        end
        if (i_we) begin
            if (!r_hold_valid && out_free) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_hold       = i_res;
                n_hold_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

/* src/byte_transliterator_unit.sv */
// ----------------------------------------------------------------------------
// Byte transliterator unit
// tr-style byte mapping: items build a source and a target list, translate
// items map a text byte through the first source position to the target list.
// List, mark, finish, clear and pass-through items write their result into the
// queue in the cycle they are accepted; a mapped translate reads the position
// map and then the target memory. Throughput: one list item per cycle while the
// result queue has room; no new item is taken until a translate, range end or
// reversed range end is done, and a range end adds its bytes one per cycle.
// Reset is synchronous and clears counters, flags and all presence bits at once;
// there is no clearing sweep, the block takes items in the first cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_transliterator_unit import bxl_pkg::*; #(
    parameter int unsigned SOURCE_MAX = SOURCE_MAX_DEF,
    parameter int unsigned TARGET_MAX = TARGET_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bxl_req_if.sink    i_req,
    bxl_rsp_if.source  o_rsp
);

    // Address width of the source list memory. Positions in the position map
    // are source list addresses, so they share that width.
    localparam int unsigned SAW = (SOURCE_MAX > 1) ? $clog2(SOURCE_MAX) : 1;

    t_mem_req          pos_req, src_req, tgt_req;
    logic [SAW-1:0]    pos_rdata;
    logic [BYTE_W-1:0] src_rdata, tgt_rdata;
    logic              res_we, res_free;
    t_result           res, out_res;

    // The sequencer owns all list state outside the memories. It takes an item
    // only in idle and only when the result queue has room for its result, so
    // a single finished result waiting downstream does not hold up the next item.
    bxl_ctrl #(
        .SOURCE_MAX (SOURCE_MAX),
        .TARGET_MAX (TARGET_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_op        (i_req.operation),
        .i_byte      (i_req.data_byte),
        .i_res_free  (res_free),
        .o_res_we    (res_we),
        .o_res       (res),
        .o_pos       (pos_req),
        .i_pos_rdata (pos_rdata),
        .o_src       (src_req),
        .i_src_rdata (src_rdata),
        .o_tgt       (tgt_req),
        .i_tgt_rdata (tgt_rdata)
    );

    // Position map: one entry per byte value, holding the first source list
    // position of that byte. Its presence bits live in the sequencer.
    bxl_ram #(
        .DATA_W (SAW),
        .DEPTH  (BYTE_VALUES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_req   (pos_req),
        .o_rdata (pos_rdata)
    );

    // Source list bytes, read back only to find the new last byte when a
    // reversed range removes its start.
    bxl_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (SOURCE_MAX)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_req   (src_req),
        .o_rdata (src_rdata)
    );

    // Target list bytes, read by translate items and by reversed target ranges.
    bxl_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (TARGET_MAX)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_req   (tgt_req),
        .o_rdata (tgt_rdata)
    );

    // Result queue: the output register and one holding slot behind it.
    bxl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (res_we),
        .i_res   (res),
        .o_free  (res_free),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_res   (out_res)
    );

    assign o_rsp.out_byte = out_res.out_byte;
    assign o_rsp.status   = out_res.status;

endmodule

`default_nettype wire

/* src/bxl_checker.sv */
// ----------------------------------------------------------------------------
// Byte transliterator port checker
// Watches the response port of the unit and is bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_transliterator_unit_macros.svh"

module bxl_checker import bxl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [BYTE_W-1:0] i_rsp_out_byte,
    input logic [ST_W-1:0]   i_rsp_status
);

    // A stalled item keeps its value until it is taken.
    `BXL_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_out_byte) && $stable(i_rsp_status), "response item changed while stalled")

    // Reset empties the result queue.
    `BXL_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_rsp_valid, "response valid after reset")

    // Only translate items carry a byte, and those always report success.
    `BXL_ASSERT_IMPL(a_byte_ok, i_clk, i_rst_n, i_rsp_valid && (i_rsp_out_byte != '0), i_rsp_status == ST_OK, "translated byte with an error status")

endmodule

bind byte_transliterator_unit bxl_checker u_bxl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_out_byte (o_rsp.out_byte),
    .i_rsp_status   (o_rsp.status)
);

`default_nettype wire

/* sim/byte_transliterator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte transliterator unit testbench
// Drives list building, range, finish and translate items into the unit and
// checks every result against an in-order prediction of the tr-style mapping.
// Both sides idle at random in the first two of three phases. In the last one the
// receiver holds off long enough to back the unit up, and the sender waits
// for the unit to drain between phases.
// ----------------------------------------------------------------------------

module byte_transliterator_unit_tb;
    import bxl_pkg::*;

    // Marks a byte that does not appear in the source list.
    localparam logic [8:0]      NOT_IN_SOURCE = 9'h100;
    // Operation code left unused by the unit. It must produce a plain zero result.
    localparam logic [OP_W-1:0] OP_UNUSED     = 3'd7;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT    = 4000;
    localparam int unsigned DRAIN_CYCLES   = 20;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of both lists and predicts one result
    // per accepted item, in order.
    // ------------------------------------------------------------------------
    class translit_scoreboard;
        logic [8:0]  first_pos [BYTE_VALUES];
        logic [7:0]  src_bytes [BYTE_VALUES];
        logic [7:0]  tgt_bytes [BYTE_VALUES];
        int unsigned src_len;
        int unsigned tgt_len;
        logic [7:0]  src_last;
        logic [7:0]  tgt_last;
        bit          src_mark;
        bit          tgt_mark;
        t_result     expected_results [$];
        int unsigned error_count;

        function new();
            clear_lists();
            error_count = 0;
        endfunction

        function void clear_lists();
            foreach (first_pos[i]) begin
                first_pos[i] = NOT_IN_SOURCE;
                src_bytes[i] = 8'h00;
                tgt_bytes[i] = 8'h00;
            end
            src_len  = 0;
            tgt_len  = 0;
            src_last = 8'h00;
            tgt_last = 8'h00;
            src_mark = 1'b0;
            tgt_mark = 1'b0;
        endfunction

        function bit append_byte(bit to_src, logic [7:0] b);
            if (to_src) begin
                if (src_len >= SOURCE_MAX_DEF) return 1'b0;
                src_bytes[src_len] = b;
                if (first_pos[b] == NOT_IN_SOURCE) first_pos[b] = src_len[8:0];
                src_len++;
                src_last = b;
            end else begin
                if (tgt_len >= TARGET_MAX_DEF) return 1'b0;
                tgt_bytes[tgt_len] = b;
                tgt_len++;
                tgt_last = b;
            end
            return 1'b1;
        endfunction

        // Removes the last byte of a non-empty list; a source byte loses its
        // position only if this was its first occurrence.
        function logic [7:0] drop_last_byte(bit to_src);
            logic [7:0] b;
            if (to_src) begin
                b = src_last;
                src_len--;
                if (first_pos[b] == src_len[8:0]) first_pos[b] = NOT_IN_SOURCE;
                src_last = (src_len != 0) ? src_bytes[src_len - 1] : 8'h00;
            end else begin
                b = tgt_last;
                tgt_len--;
                tgt_last = (tgt_len != 0) ? tgt_bytes[tgt_len - 1] : 8'h00;
            end
            return b;
        endfunction

        function t_status expand_range(bit to_src, logic [7:0] range_end);
            int unsigned len;
            logic [7:0]  start;
            t_status     st;
            int          v;
            len = to_src ? src_len : tgt_len;
            if (len == 0) return ST_NO_START;
            start = drop_last_byte(to_src);
            if (start > range_end) return ST_REVERSED;
            st = ST_OK;
            for (v = start; v <= range_end; v++) begin
                if (!append_byte(to_src, v[7:0])) st = ST_OVERFLOW;
            end
            return st;
        endfunction

        function t_status add_pattern_byte(bit to_src, logic [7:0] b);
            if (to_src && src_mark) begin
                src_mark = 1'b0;
                return expand_range(1'b1, b);
            end
            if (!to_src && tgt_mark) begin
                tgt_mark = 1'b0;
                return expand_range(1'b0, b);
            end
            return append_byte(to_src, b) ? ST_OK : ST_OVERFLOW;
        endfunction

        function logic [7:0] map_byte(logic [7:0] c);
            int unsigned pos;
            if (c == 8'h00 || tgt_len == 0) return c;
            if (first_pos[c] == NOT_IN_SOURCE) return c;
            pos = first_pos[c];
            if (pos >= tgt_len) pos = tgt_len - 1;
            return tgt_bytes[pos];
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [7:0] b);
            t_result r;
            r.out_byte = 8'h00;
            r.status   = ST_OK;
            case (op)
                OP_CLEAR:     clear_lists();
                OP_ADD_SRC:   r.status = add_pattern_byte(1'b1, b);
                OP_SRC_MARK:  src_mark = 1'b1;
                OP_ADD_TGT:   r.status = add_pattern_byte(1'b0, b);
                OP_TGT_MARK:  tgt_mark = 1'b1;
                OP_FINISH:    if (src_mark || tgt_mark) r.status = ST_DANGLING;
                OP_TRANSLATE: r.out_byte = map_byte(b);
                default: begin
                end
            endcase
            expected_results.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            error_count++;
        endtask

        task check_result(logic [7:0] ob, logic [ST_W-1:0] st);
            t_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with nothing expected: out_byte %02h status %0d",
                                 ob, st));
                return;
            end
            want = expected_results.pop_front();
            if (ob !== want.out_byte)
                report($sformatf("out_byte %02h, expected %02h", ob, want.out_byte));
            if (st !== want.status)
                report($sformatf("status %0d, expected %0d", st, want.status));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the unit.
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    bxl_req_if req_if ();
    bxl_rsp_if rsp_if ();

    byte_transliterator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    translit_scoreboard sb;
    int unsigned        items_sent;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    // The stimulus bumps the first counter to ask for a long receiver hold-off;
    // the receiver counts the hold itself and catches up with the second.
    int unsigned        hold_requests_made;
    int unsigned        hold_requests_seen;
    int unsigned        hold_left;
    int unsigned        quiet_cycles;

    // ------------------------------------------------------------------------
    // Receiver: checks each accepted result and chooses ready for the next
    // cycle, either at random or held low for a long stretch on request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.out_byte, rsp_if.status);
            if (hold_requests_seen != hold_requests_made) begin
                hold_requests_seen = hold_requests_made;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each is entered just after a rising edge. Valid stays high
    // between back-to-back items and drops only while the sender idles.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [OP_W-1:0] op, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.data_byte <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_item(op, b);
        items_sent++;
    endtask

    // Stops offering items until every predicted result has been checked.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Appends n entries to one list around a base byte: single bytes, short
    // ranges, reversed ranges and marks with no fresh start byte.
    task automatic load_list(bit to_src, logic [7:0] base, int unsigned n);
        logic [OP_W-1:0] add_op;
        logic [OP_W-1:0] mark_op;
        logic [7:0]      a;
        int unsigned     pick;
        add_op  = to_src ? OP_ADD_SRC : OP_ADD_TGT;
        mark_op = to_src ? OP_SRC_MARK : OP_TGT_MARK;
        repeat (n) begin
            a    = base + 8'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_item(add_op, a);
            end else if (pick < 85) begin
                send_item(add_op, a);
                send_item(mark_op, 8'($urandom));
                send_item(add_op, a + 8'($urandom_range(0, 12)));
            end else if (pick < 92) begin
                send_item(add_op, a);
                send_item(mark_op, 8'($urandom));
                send_item(add_op, a - 8'($urandom_range(1, 8)));
            end else begin
                send_item(mark_op, 8'($urandom));
                send_item(add_op, a);
            end
        end
    endtask

    // Adds a long range and one more byte to one list, which may run it past its capacity.
    task automatic overfill_list(bit to_src);
        send_item(to_src ? OP_ADD_SRC : OP_ADD_TGT, 8'($urandom_range(0, 40)));
        send_item(to_src ? OP_SRC_MARK : OP_TGT_MARK, 8'($urandom));
        send_item(to_src ? OP_ADD_SRC : OP_ADD_TGT, 8'hFF);
        send_item(to_src ? OP_ADD_SRC : OP_ADD_TGT, 8'($urandom));
    endtask

    // One well-formed table build followed by text to translate, with a
    // little noise mixed in.
    task automatic run_session();
        logic [7:0]  src_base;
        logic [7:0]  c;
        int unsigned pick;
        src_base = 8'($urandom);
        if ($urandom_range(0, 99) < 85) send_item(OP_CLEAR, 8'($urandom));
        if ($urandom_range(0, 99) < 6) overfill_list(1'($urandom_range(0, 1)));
        load_list(1'b1, src_base, $urandom_range(1, 8));
        if ($urandom_range(0, 99) < 90) load_list(1'b0, 8'($urandom), $urandom_range(1, 8));
        // Sometimes finish with a mark still waiting for its end byte.
        pick = $urandom_range(0, 99);
        if (pick < 8) send_item(OP_SRC_MARK, 8'($urandom));
        else if (pick < 15) send_item(OP_TGT_MARK, 8'($urandom));
        send_item(OP_FINISH, 8'($urandom));
        repeat ($urandom_range(8, 30)) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) c = src_base + 8'($urandom_range(0, 20));
            else if (pick < 75) c = 8'h00;
            else c = 8'($urandom);
            send_item(OP_TRANSLATE, c);
        end
        repeat ($urandom_range(0, 3))
            send_item(OP_W'(OP_CLEAR + $urandom_range(0, OP_TRANSLATE)), 8'($urandom));
    endtask

    task automatic run_directed();
        send_item(OP_TRANSLATE, 8'h41);   // both lists empty
        send_item(OP_SRC_MARK,  8'h00);
        send_item(OP_ADD_SRC,   8'h10);   // range end with no start byte
        send_item(OP_ADD_SRC,   8'h61);
        send_item(OP_SRC_MARK,  8'h00);
        send_item(OP_SRC_MARK,  8'h00);   // mark while one is already waiting
        send_item(OP_ADD_SRC,   8'h63);   // 61..63
        send_item(OP_SRC_MARK,  8'h00);
        send_item(OP_ADD_SRC,   8'h50);   // reversed: 63 stays removed
        send_item(OP_ADD_SRC,   8'hFF);
        send_item(OP_ADD_TGT,   8'h41);
        send_item(OP_TGT_MARK,  8'h00);
        send_item(OP_FINISH,    8'h00);   // dangling range
        send_item(OP_ADD_TGT,   8'h42);   // 41..42
        send_item(OP_FINISH,    8'hFF);
        send_item(OP_TRANSLATE, 8'h62);
        send_item(OP_TRANSLATE, 8'hFF);   // clipped to the last target byte
        send_item(OP_TRANSLATE, 8'h00);
        send_item(OP_TRANSLATE, 8'h63);   // absent from source
        send_item(OP_UNUSED,    8'hA5);
        send_item(OP_ADD_TGT,   8'h00);
        send_item(OP_TGT_MARK,  8'h00);
        send_item(OP_ADD_TGT,   8'hFF);   // range keeps only what fits
        send_item(OP_ADD_TGT,   8'h07);   // list full
        send_item(OP_TRANSLATE, 8'hFF);
        send_item(OP_CLEAR,     8'h00);
        send_item(OP_TRANSLATE, 8'h61);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed items, then three phases, the first two with
    // random idling, and a receiver hold-off at the start of the last one.
    // ------------------------------------------------------------------------
    initial begin
        sb                 = new();
        items_sent         = 0;
        hold_requests_made = 0;
        hold_requests_seen = 0;
        hold_left          = 0;
        quiet_cycles       = 0;
        send_idle_pct      = 19;
        recv_idle_pct      = 85;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.operation   = OP_CLEAR;
        req_if.data_byte   = 8'h00;
        rsp_if.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        while (items_sent < 350) run_session();
        wait_drained();

        send_idle_pct = 85;
        recv_idle_pct = 19;
        while (items_sent < 650) run_session();
        wait_drained();

        // The receiver holds off while the sender keeps offering items, so
        // the unit fills up and pushes back on its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests_made++;
        repeat (60) send_item(OP_TRANSLATE, 8'($urandom));
        wait_drained();
        while (items_sent < 930) run_session();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/bxl_pkg.sv
src/bxl_ifs.sv
src/bxl_ram.sv
src/bxl_ctrl.sv
src/bxl_outq.sv
src/byte_transliterator_unit.sv
src/bxl_checker.sv
sim/byte_transliterator_unit_tb.sv
